>>> design/cmhm_pkg.sv
// ----------------------------------------------------------------------------
// cmhm_pkg: shared types and constants for the chained hash map unit
// Operation codes, command and response item layouts, hash constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cmhm_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic        ST_OK        = 1'b0;
  localparam logic        ST_POOL_FULL = 1'b1;

  localparam logic [30:0] HASH_XOR      = 31'h7FFF_FFFF;
  localparam logic [10:0] BUCKETS_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] value_out;
    logic        status;
    logic [10:0] entry_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/cmhm_bucket_calc.sv
// ----------------------------------------------------------------------------
// cmhm_bucket_calc: bucket index of a key
// Integer mixing of the key, then a bit-serial remainder by the
// clamped bucket count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cmhm_bucket_calc import cmhm_pkg::*; #(
  parameter int MAX_BUCKETS = 1024,
  parameter int BW          = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [63:0]   key,
  input  wire logic [10:0]   bucket_count,
  output logic               done,
  output logic [BW-1:0]      bucket
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MIX2 = 3'd1;
  localparam logic [2:0] P_MIX3 = 3'd2;
  localparam logic [2:0] P_MIX4 = 3'd3;
  localparam logic [2:0] P_DIV  = 3'd4;

  logic [2:0]  phase;
  logic [63:0] h;
  logic [30:0] dvd;
  logic [10:0] rem;
  logic [10:0] nb;
  logic [4:0]  cnt;

  logic [10:0] nb_clamped;
  logic [63:0] t2, t3, t4;
  logic [11:0] r_shift;
  logic [11:0] r_sub;
  logic [10:0] rem_next;

  always_comb begin
    if (bucket_count == 11'd0) begin
      nb_clamped = 11'd1;
    end else if ({6'd0, bucket_count} > 17'(MAX_BUCKETS)) begin
      nb_clamped = 11'(MAX_BUCKETS);
    end else begin
      nb_clamped = bucket_count;
    end
    t2       = h ^ (h >> 31);
    t3       = h ^ (h >> 11);
    t4       = h ^ (h >> 22);
    r_shift  = {rem, dvd[30]};
    r_sub    = r_shift - {1'b0, nb};
    rem_next = (r_shift >= {1'b0, nb}) ? r_sub[10:0] : r_shift[10:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            h     <= (~key) + (key << 18);
            nb    <= nb_clamped;
            phase <= P_MIX2;
          end
        end
        P_MIX2: begin
          // times 21 as 16 + 4 + 1
          h     <= (t2 << 4) + (t2 << 2) + t2;
          phase <= P_MIX3;
        end
        P_MIX3: begin
          h     <= t3 + (t3 << 6);
          phase <= P_MIX4;
        end
        P_MIX4: begin
          dvd   <= {2'b00, t4[31:3]} ^ HASH_XOR;
          rem   <= 11'd0;
          cnt   <= 5'd0;
          phase <= P_DIV;
        end
        P_DIV: begin
          rem <= rem_next;
          dvd <= {dvd[29:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            bucket <= BW'(rem_next);
            done   <= 1'b1;
            phase  <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/chained_hash_map_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_map_unit: key-value table with separate chaining
// Bucket heads and node records live in two single-port synchronous memories.
// ----------------------------------------------------------------------------
// Issue a command with start while busy is low; the item is taken on that
// edge. Exactly one response comes back per command, on rsp with done high
// for a single cycle; the receiver cannot stall it, so sample it then.
// Sequence: a clear sweeps the bucket memory, one bucket per cycle, over all
// MAX_BUCKETS buckets and then raises done. Any other command first computes
// the bucket (integer mixing plus a 31-step serial remainder), then reads the
// bucket head, then walks the chain with one node-memory read per node
// visited, then does the node and link writes of an insert or remove, and
// finally responds. After reset the same sweep of all MAX_BUCKETS buckets
// runs with busy high before the first command is taken.
// bucket_count may be written through cfg_we/cfg_data only while idle;
// zero acts as one bucket, values above MAX_BUCKETS act as MAX_BUCKETS.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_unit import cmhm_pkg::*; #(
  parameter int MAX_BUCKETS = 1024,
  parameter int NODE_POOL   = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    cmd,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_data,
  output logic             done,
  output out_item_t        rsp
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int IW = $clog2(NODE_POOL + 1);
  // link value meaning "no node"
  localparam logic [IW-1:0] NIL = IW'(NODE_POOL);
  localparam logic [BW-1:0] LAST_BKT = BW'(MAX_BUCKETS - 1);

  typedef struct packed {
    logic [63:0]   key;
    logic [63:0]   value;
    logic [IW-1:0] next;
    logic [IW-1:0] prev;
  } node_t;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_HASH = 5'd2;
  localparam logic [4:0] S_HRD  = 5'd3;
  localparam logic [4:0] S_HEAD = 5'd4;
  localparam logic [4:0] S_WALK = 5'd5;
  localparam logic [4:0] S_UPD  = 5'd6;
  localparam logic [4:0] S_MISS = 5'd7;
  localparam logic [4:0] S_AFR  = 5'd8;
  localparam logic [4:0] S_AFD  = 5'd9;
  localparam logic [4:0] S_NWR  = 5'd10;
  localparam logic [4:0] S_HPR  = 5'd11;
  localparam logic [4:0] S_HPW  = 5'd12;
  localparam logic [4:0] S_BWR  = 5'd13;
  localparam logic [4:0] S_RM0  = 5'd14;
  localparam logic [4:0] S_RPW  = 5'd15;
  localparam logic [4:0] S_RXR  = 5'd16;
  localparam logic [4:0] S_RXW  = 5'd17;
  localparam logic [4:0] S_RNW  = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;

  // sequencer state
  logic [4:0]    state;
  logic [1:0]    cur_op;
  logic [63:0]   cur_key;
  logic [63:0]   cur_val;
  logic [BW-1:0] bidx;
  logic [IW-1:0] hd;        // chain head seen at lookup time
  logic [IW-1:0] cur;       // node whose record is being read
  logic [IW-1:0] new_n;
  node_t         hold;      // record of the matched node
  logic [IW-1:0] free_head; // top of the free list
  logic [IW-1:0] fresh;     // first node never handed out since clear
  logic [IW-1:0] nf_next;
  logic [IW-1:0] count;
  logic [10:0]   bc;
  logic [BW-1:0] clr_idx;
  logic          clr_rsp;
  logic          res_found;
  logic [63:0]   res_val;
  logic          res_status;

  // bucket head memory
  logic [IW-1:0] bk_mem [MAX_BUCKETS];
  logic          bk_we, bk_re;
  logic [BW-1:0] bk_addr;
  logic [IW-1:0] bk_wdata, bk_rdata;

  // node record memory
  node_t         nd_mem [NODE_POOL];
  logic          nd_we, nd_re;
  logic [IW-1:0] nd_addr;
  node_t         nd_wdata, nd_rdata;

  // bucket calculation
  logic          hc_start, hc_done;
  logic [BW-1:0] hc_bucket;

  logic key_hit;

  assign busy     = (state != S_IDLE);
  assign hc_start = (state == S_IDLE) && start && (cmd.op != OP_CLEAR);
  assign key_hit  = (nd_rdata.key == cur_key);

  cmhm_bucket_calc #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .BW         (BW)
  ) u_calc (
    .clk         (clk),
    .rst         (rst),
    .start       (hc_start),
    .key         (cmd.key),
    .bucket_count(bc),
    .done        (hc_done),
    .bucket      (hc_bucket)
  );

  always_ff @(posedge clk) begin
    if (bk_we) begin
      bk_mem[bk_addr] <= bk_wdata;
    end
    if (bk_re) begin
      bk_rdata <= bk_mem[bk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nd_we) begin
      nd_mem[nd_addr[NW-1:0]] <= nd_wdata;
    end
    if (nd_re) begin
      nd_rdata <= nd_mem[nd_addr[NW-1:0]];
    end
  end

  // memory port control: one access per memory per cycle, all in sequence
  always_comb begin
    bk_we    = 1'b0;
    bk_re    = 1'b0;
    bk_addr  = bidx;
    bk_wdata = NIL;
    nd_we    = 1'b0;
    nd_re    = 1'b0;
    nd_addr  = cur;
    nd_wdata = hold;
    case (state)
      S_CLR: begin
        bk_we   = 1'b1;
        bk_addr = clr_idx;
      end
      S_HRD: begin
        bk_re = 1'b1;
      end
      S_HEAD: begin
        nd_re   = (bk_rdata != NIL);
        nd_addr = bk_rdata;
      end
      S_WALK: begin
        nd_re   = !key_hit && (nd_rdata.next != NIL);
        nd_addr = nd_rdata.next;
      end
      S_UPD: begin
        nd_we          = 1'b1;
        nd_wdata.value = cur_val;
      end
      S_AFR: begin
        nd_re   = 1'b1;
        nd_addr = free_head;
      end
      S_NWR: begin
        nd_we    = 1'b1;
        nd_addr  = free_head;
        nd_wdata = '{key: cur_key, value: cur_val, next: hd, prev: NIL};
      end
      S_HPR: begin
        nd_re   = 1'b1;
        nd_addr = hd;
      end
      S_HPW: begin
        nd_we         = 1'b1;
        nd_addr       = hd;
        nd_wdata      = nd_rdata;
        nd_wdata.prev = new_n;
      end
      S_BWR: begin
        bk_we    = 1'b1;
        bk_wdata = new_n;
      end
      S_RM0: begin
        // unlink: the head moves on, or the predecessor gets read
        if (hold.prev == NIL) begin
          bk_we    = 1'b1;
          bk_wdata = hold.next;
        end else begin
          nd_re   = 1'b1;
          nd_addr = hold.prev;
        end
      end
      S_RPW: begin
        nd_we         = 1'b1;
        nd_addr       = hold.prev;
        nd_wdata      = nd_rdata;
        nd_wdata.next = hold.next;
      end
      S_RXR: begin
        nd_re   = (hold.next != NIL);
        nd_addr = hold.next;
      end
      S_RXW: begin
        nd_we         = 1'b1;
        nd_addr       = hold.next;
        nd_wdata      = nd_rdata;
        nd_wdata.prev = hold.prev;
      end
      S_RNW: begin
        // push the removed node onto the free list
        nd_we    = 1'b1;
        nd_wdata = '{key: hold.key, value: hold.value, next: free_head, prev: NIL};
      end
      default: begin
        bk_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      clr_rsp   <= 1'b0;
      free_head <= '0;
      fresh     <= '0;
      count     <= '0;
      bc        <= BUCKETS_RESET;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        bc <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_op     <= cmd.op;
            cur_key    <= cmd.key;
            cur_val    <= cmd.value;
            res_found  <= 1'b0;
            res_val    <= 64'd0;
            res_status <= ST_OK;
            if (cmd.op == OP_CLEAR) begin
              clr_idx   <= '0;
              clr_rsp   <= 1'b1;
              free_head <= '0;
              fresh     <= '0;
              count     <= '0;
              state     <= S_CLR;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_BKT) begin
            state <= clr_rsp ? S_DONE : S_IDLE;
          end
        end
        S_HASH: begin
          if (hc_done) begin
            bidx  <= hc_bucket;
            state <= S_HRD;
          end
        end
        S_HRD: begin
          state <= S_HEAD;
        end
        S_HEAD: begin
          hd  <= bk_rdata;
          cur <= bk_rdata;
          state <= (bk_rdata == NIL) ? S_MISS : S_WALK;
        end
        S_WALK: begin
          if (key_hit) begin
            hold      <= nd_rdata;
            res_found <= 1'b1;
            case (cur_op)
              OP_INSERT: state <= S_UPD;
              OP_REMOVE: begin
                res_val <= nd_rdata.value;
                state   <= S_RM0;
              end
              default: begin
                res_val <= nd_rdata.value;
                state   <= S_DONE;
              end
            endcase
          end else if (nd_rdata.next == NIL) begin
            state <= S_MISS;
          end else begin
            cur <= nd_rdata.next;
          end
        end
        S_UPD: begin
          state <= S_DONE;
        end
        S_MISS: begin
          if (cur_op != OP_INSERT) begin
            state <= S_DONE;
          end else if (free_head == NIL) begin
            res_status <= ST_POOL_FULL;
            state      <= S_DONE;
          end else if (free_head == fresh) begin
            // untouched node: its successor is simply the next index
            nf_next <= fresh + 1'b1;
            fresh   <= fresh + 1'b1;
            state   <= S_NWR;
          end else begin
            state <= S_AFR;
          end
        end
        S_AFR: begin
          state <= S_AFD;
        end
        S_AFD: begin
          nf_next <= nd_rdata.next;
          state   <= S_NWR;
        end
        S_NWR: begin
          new_n     <= free_head;
          free_head <= nf_next;
          count     <= count + 1'b1;
          state     <= (hd == NIL) ? S_BWR : S_HPR;
        end
        S_HPR: begin
          state <= S_HPW;
        end
        S_HPW: begin
          state <= S_BWR;
        end
        S_BWR: begin
          state <= S_DONE;
        end
        S_RM0: begin
          state <= (hold.prev == NIL) ? S_RXR : S_RPW;
        end
        S_RPW: begin
          state <= S_RXR;
        end
        S_RXR: begin
          state <= (hold.next == NIL) ? S_RNW : S_RXW;
        end
        S_RXW: begin
          state <= S_RNW;
        end
        S_RNW: begin
          free_head <= cur;
          if (count != '0) begin
            count <= count - 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done            <= 1'b1;
          rsp.found       <= res_found;
          rsp.value_out   <= (cur_op == OP_INSERT) ? 64'd0 : res_val;
          rsp.status      <= res_status;
          rsp.entry_count <= 11'(count);
          clr_rsp         <= 1'b0;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/cmhm_checker.sv
// ----------------------------------------------------------------------------
// cmhm_checker: port-level checks for the chained hash map unit
// Watches the command and response ports; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cmhm_checker import cmhm_pkg::*; #(
  parameter int NODE_POOL = 1024
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done,
  input wire out_item_t rsp
);

  // a taken item always makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but unit not busy");

  // responses are single-cycle and never back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("response strobe held");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("response without work");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == ST_POOL_FULL)) |-> !rsp.found)
    else $error("pool full reported for a present key");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> ({21'd0, rsp.entry_count} <= 32'(NODE_POOL)))
    else $error("entry count beyond pool size");

endmodule

bind chained_hash_map_unit cmhm_checker #(.NODE_POOL(NODE_POOL)) u_cmhm_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

`default_nettype wire
